>>> sv/vfc_pkg.sv
// Shared types and constants for the varying filter convolution block.
`default_nettype none
package vfc_pkg;

    localparam int MAX_TAPS = 16;
    localparam int WINDOW   = 64;

    localparam int COEF_W = 56;
    localparam int ACC_W  = 64;

    localparam logic [1:0] OP_LAG   = 2'd0;
    localparam logic [1:0] OP_BEGIN = 2'd1;
    localparam logic [1:0] OP_END   = 2'd2;
    localparam logic [1:0] OP_SAMP  = 2'd3;

    localparam logic signed [COEF_W-1:0] C56_MAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic signed [COEF_W-1:0] C56_MIN = {1'b1, {(COEF_W-1){1'b0}}};

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_DIV   = 7'b0000010,
        ST_MUL   = 7'b0000100,
        ST_ACC   = 7'b0001000,
        ST_STEP  = 7'b0010000,
        ST_OUT   = 7'b0100000,
        ST_CLR   = 7'b1000000
    } state_t;

    typedef struct packed {
        logic start;
        logic signed [57:0] dividend;
        logic [15:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic done;
        logic signed [57:0] quotient;
    } div_rsp_t;

endpackage
`default_nettype wire

>>> sv/vfc_div.sv
// Restoring divider, one quotient bit per cycle, signed dividend by unsigned divisor.
`default_nettype none
module vfc_div
    import vfc_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);
    logic [57:0] rem_reg, rem_next;
    logic [57:0] quo_reg, quo_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        neg_reg, neg_next;
    logic        done_reg, done_next;
    logic [15:0] den_reg, den_next;
    logic [58:0] trial;
    logic [57:0] shifted;

    always_comb begin
        rem_next = rem_reg; quo_next = quo_reg; cnt_next = cnt_reg;
        busy_next = busy_reg; neg_next = neg_reg; done_next = 1'b0;
        den_next = den_reg;
        shifted = {rem_reg[56:0], quo_reg[57]};
        trial = {1'b0, shifted} - {43'd0, den_reg};
        if (req.start) begin
            neg_next = req.dividend[57];
            quo_next = req.dividend[57] ? 58'(-req.dividend) : 58'(req.dividend);
            rem_next = '0;
            den_next = (req.divisor == 16'd0) ? 16'd1 : req.divisor;
            cnt_next = 6'd58;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[58]) begin
                rem_next = trial[57:0];
                quo_next = {quo_reg[56:0], 1'b1};
            end else begin
                rem_next = shifted;
                quo_next = {quo_reg[56:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0; done_reg <= 1'b0; cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next; done_reg <= done_next; cnt_reg <= cnt_next;
        end
        rem_reg <= rem_next; quo_reg <= quo_next; neg_reg <= neg_next;
        den_reg <= den_next;
    end

    assign rsp = '{done: done_reg,
                   quotient: neg_reg ? -$signed(quo_reg) : $signed(quo_reg)};
endmodule
`default_nettype wire

>>> sv/varying_filter_conv_forward_top.sv
// Top level of the linearly varying nonstationary convolution block.
`default_nettype none
// Each input word is one operation. A lag or begin load is decoded and
// written in ST_DIV. An end-corner load runs a bit-serial divider. A sample
// word walks the taps in use through one shared 32x32 multiplier and one
// 64-bit saturating adder. After decode, the scatter runs a multiply with
// window read (ST_MUL), then an add with write back (ST_ACC), per tap;
// then the coefficient step (ST_STEP) runs tap by tap, then fetch and emit.
// An inactive sample or zero taps skips scatter and step. s_tready is low
// while a word is at work. A finished result waits in the output register
// without holding off the next word; a sample word stalls at its emit step
// until that register frees up. The accumulator window is a memory with one
// registered read port; after reset a clearing pass sweeps every entry,
// during which no word is accepted. Tap and window sizes are package
// constants. tap_count lies at byte address 0 of the APB port.
module varying_filter_conv_forward_top
    import vfc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // op[1:0], tap[5:2], lag_value[11:6], coef[43:12], block_len[59:44],
    // sample[91:60], prior[123:92], active[124], zeros up to 127
    input  wire logic [127:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // out_value[31:0], saturated[32], zeros up to 39
    output logic [39:0]      m_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    localparam int TW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int WW = $clog2(WINDOW);
    localparam int NW = $clog2(MAX_TAPS + 1);

    logic [4:0] tap_count_reg;
    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {27'd0, tap_count_reg} : 32'd0;
    always_ff @(posedge aclk) begin
        if (!aresetn) tap_count_reg <= 5'd1;
        else if (psel && penable && pwrite && paddr == 2'd0) tap_count_reg <= pwdata[4:0];
    end

    logic [5:0]              lag_reg  [MAX_TAPS];
    logic signed [COEF_W-1:0] cnow_reg [MAX_TAPS];
    logic signed [COEF_W-1:0] cstep_reg[MAX_TAPS];
    logic [ACC_W-1:0]        acc_mem  [WINDOW];

    state_t state_reg;
    logic [WW-1:0] ptr_reg, clr_reg;
    logic          clearing_reg;
    logic [NW-1:0] idx_reg, ntaps;
    logic [124:0]  word_reg;
    logic          div_wait_reg;
    logic signed [63:0] prod_reg;
    logic [ACC_W-1:0] rd_reg;
    logic [WW-1:0]  addr_reg;
    logic          out_full_reg;
    logic [39:0]   out_reg;
    div_req_t dreq;
    div_rsp_t drsp;

    wire [1:0]  w_op  = word_reg[1:0];
    wire [3:0]  w_tap = word_reg[5:2];
    wire signed [31:0] w_coef   = word_reg[43:12];
    wire signed [31:0] w_sample = word_reg[91:60];
    wire signed [31:0] w_prior  = word_reg[123:92];
    wire        w_act = word_reg[124];
    wire        tap_ok = ({28'd0, w_tap} < 32'(MAX_TAPS));
    wire [TW-1:0] ltap = w_tap[TW-1:0];
    wire [TW-1:0] itap = idx_reg[TW-1:0];

    assign ntaps = ({27'd0, tap_count_reg} < 32'(MAX_TAPS)) ? NW'(tap_count_reg) : NW'(MAX_TAPS);
    assign s_tready = (state_reg == ST_IDLE) && !clearing_reg;

    // Emit once the output register is free or being drained this cycle.
    wire out_load = (state_reg == ST_OUT) && (!out_full_reg || m_tready);

    vfc_div u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp));

    // Kick the divider on the first decode cycle of an end load.
    wire signed [COEF_W-1:0] coef_sc = {{4{w_coef[31]}}, w_coef, 20'd0};
    assign dreq = '{start: (state_reg == ST_DIV) && (w_op == OP_END) && tap_ok && !div_wait_reg,
                    dividend: 58'(coef_sc) - 58'(cnow_reg[ltap]),
                    divisor: word_reg[59:44]};

    // Shared unit: one multiplier and one saturating adder.
    logic signed [31:0] mul_a, mul_b;
    logic signed [ACC_W-1:0] add_a, add_b, add_s;
    logic add_ov;
    always_comb begin
        mul_a = cnow_reg[itap][55:24];
        mul_b = w_sample;
        add_a = $signed(rd_reg);
        add_b = prod_reg >>> 24;
        case (state_reg)
            ST_STEP: begin
                add_a = 64'(cnow_reg[itap]);
                add_b = 64'(cstep_reg[itap]);
            end
            ST_OUT: add_b = 64'(w_prior);
            default: ;
        endcase
        add_s = add_a + add_b;
        add_ov = (add_a[63] == add_b[63]) && (add_s[63] != add_a[63]);
    end
    wire signed [ACC_W-1:0] add_sat = add_ov ? (add_a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}})
                                             : add_s;
    wire signed [COEF_W-1:0] step_sat = (add_s > 64'(C56_MAX)) ? C56_MAX :
                                        (add_s < 64'(C56_MIN)) ? C56_MIN : add_s[55:0];
    wire signed [57:0] q = drsp.quotient;
    wire signed [COEF_W-1:0] q_sat = (q > 58'(C56_MAX)) ? C56_MAX :
                                     (q < 58'(C56_MIN)) ? C56_MIN : q[55:0];

    logic [WW-1:0] tgt;
    assign tgt = WW'(ptr_reg + WW'(lag_reg[itap]));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE; ptr_reg <= '0; clr_reg <= '0; clearing_reg <= 1'b1;
            out_full_reg <= 1'b0; div_wait_reg <= 1'b0;
            for (int i = 0; i < MAX_TAPS; i++) begin
                lag_reg[i] <= '0; cnow_reg[i] <= '0; cstep_reg[i] <= '0;
            end
        end else begin
            if (clearing_reg) begin
                acc_mem[clr_reg] <= '0;
                clr_reg <= clr_reg + WW'(1);
                if (clr_reg == WW'(WINDOW - 1)) clearing_reg <= 1'b0;
            end
            // Hold the result until it is taken; reload it on emit.
            if (out_load) out_full_reg <= 1'b1;
            else if (m_tready) out_full_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid && s_tready) begin
                        word_reg <= s_tdata[124:0];
                        state_reg <= ST_DIV;
                        idx_reg <= '0;
                    end
                end
                ST_DIV: begin
                    // Decode the held word.
                    if (w_op == OP_LAG) begin
                        if (tap_ok) lag_reg[ltap] <= word_reg[11:6];
                        state_reg <= ST_IDLE;
                    end else if (w_op == OP_BEGIN) begin
                        if (tap_ok) cnow_reg[ltap] <= coef_sc;
                        state_reg <= ST_IDLE;
                    end else if (w_op == OP_END) begin
                        if (!tap_ok) state_reg <= ST_IDLE;
                        else if (!div_wait_reg) div_wait_reg <= 1'b1;
                        else if (drsp.done) begin
                            cstep_reg[ltap] <= q_sat;
                            div_wait_reg <= 1'b0;
                            state_reg <= ST_IDLE;
                        end
                    end else begin
                        if (w_act && idx_reg < ntaps) state_reg <= ST_MUL;
                        else state_reg <= ST_CLR;
                    end
                end
                ST_MUL: begin
                    prod_reg <= mul_a * mul_b;
                    addr_reg <= tgt;
                    rd_reg <= acc_mem[tgt];
                    state_reg <= ST_ACC;
                end
                ST_ACC: begin
                    acc_mem[addr_reg] <= add_sat;
                    if (idx_reg + NW'(1) < ntaps) begin
                        idx_reg <= idx_reg + NW'(1);
                        state_reg <= ST_MUL;
                    end else begin
                        idx_reg <= '0;
                        state_reg <= ST_STEP;
                    end
                end
                ST_STEP: begin
                    cnow_reg[itap] <= step_sat;
                    idx_reg <= idx_reg + NW'(1);
                    if (idx_reg + NW'(1) >= ntaps) state_reg <= ST_CLR;
                end
                ST_CLR: begin
                    // Fetch the finished position.
                    rd_reg <= acc_mem[ptr_reg];
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_load) begin
                        out_reg[31:0] <= (add_sat > 64'sd2147483647) ? 32'h7fffffff :
                                         (add_sat < -64'sd2147483648) ? 32'h80000000 :
                                         add_sat[31:0];
                        out_reg[32] <= (add_sat > 64'sd2147483647) ||
                                       (add_sat < -64'sd2147483648);
                        out_reg[39:33] <= '0;
                        acc_mem[ptr_reg] <= '0;
                        ptr_reg <= ptr_reg + WW'(1);
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = out_full_reg;
    assign m_tdata  = out_reg;
endmodule
`default_nettype wire

>>> verif/tb.sv
// Self-checking testbench for the varying filter convolution block.
`default_nettype none
module tb
    import vfc_pkg::*;
();

    localparam int NTAPS = 16;
    localparam int WIN   = 64;
    localparam int N_RAND = 850;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    // op[1:0], tap[5:2], lag_value[11:6], coef[43:12], block_len[59:44],
    // sample[91:60], prior[123:92], active[124], zeros up to 127
    logic [127:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // out_value[31:0], saturated[32], zeros up to 39
    logic [39:0]  m_tdata;
    logic         psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [1:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    varying_filter_conv_forward_top dut (.*);

    always #5 aclk = ~aclk;

    typedef struct packed {
        logic        active;
        logic [31:0] prior;
        logic [31:0] sample;
        logic [15:0] block_len;
        logic [31:0] coef;
        logic [5:0]  lag_value;
        logic [3:0]  tap;
        logic [1:0]  op;
    } conv_word_t;

    typedef struct packed {
        logic        saturated;
        logic [31:0] out_value;
    } conv_out_t;

    typedef struct packed {
        logic       has_exp;
        conv_out_t  exp;
        conv_word_t w;
    } dir_row_t;

    // Predictor state, mirrors the block's tables.
    logic [4:0]         taps_reg;
    logic [5:0]         lag_mem [NTAPS];
    logic signed [55:0] coef_cur [NTAPS];
    logic signed [55:0] coef_inc [NTAPS];
    logic signed [63:0] acc_mem [WIN];
    logic [5:0]         pos;

    conv_out_t out_fifo[$];
    int        err_cnt = 0;
    bit        sender_done = 1'b0;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
        err_cnt++;
    endtask

    function automatic logic signed [55:0] sat56(input logic signed [127:0] v);
        if (v > 128'sd36028797018963967) return C56_MAX;
        if (v < -128'sd36028797018963968) return C56_MIN;
        return v[55:0];
    endfunction

    function automatic logic signed [63:0] sat64(input logic signed [127:0] v);
        if (v > 128'sd9223372036854775807) return {1'b0, {63{1'b1}}};
        if (v < -128'sd9223372036854775808) return {1'b1, 63'd0};
        return v[63:0];
    endfunction

    // Apply one word to the predictor; queue the result of a sample word.
    task automatic predict_conv(input conv_word_t w);
        logic signed [127:0] wide, dv, cc, term;
        logic signed [127:0] blen;
        int n;
        conv_out_t r;
        case (w.op)
            OP_LAG: lag_mem[w.tap] = w.lag_value;
            OP_BEGIN: coef_cur[w.tap] = 56'($signed(w.coef) * 128'sd1048576);
            OP_END: begin
                blen = (w.block_len == 0) ? 128'sd1 : $signed({112'd0, w.block_len});
                dv = $signed(w.coef) * 128'sd1048576 - coef_cur[w.tap];
                coef_inc[w.tap] = sat56(dv / blen);
            end
            default: begin
                n = (taps_reg > NTAPS) ? NTAPS : taps_reg;
                if (w.active) begin
                    for (int i = 0; i < n; i++) begin
                        cc = coef_cur[i] >>> 24;
                        term = (cc * $signed(w.sample)) >>> 24;
                        acc_mem[6'(pos + lag_mem[i])] =
                            sat64(acc_mem[6'(pos + lag_mem[i])] + term);
                    end
                    for (int i = 0; i < n; i++)
                        coef_cur[i] = sat56(coef_cur[i] + coef_inc[i]);
                end
                wide = acc_mem[pos] + $signed(w.prior);
                wide = sat64(wide);
                r.saturated = 1'b0;
                if (wide > 128'sd2147483647) begin
                    wide = 128'sd2147483647; r.saturated = 1'b1;
                end else if (wide < -128'sd2147483648) begin
                    wide = -128'sd2147483648; r.saturated = 1'b1;
                end
                r.out_value = wide[31:0];
                acc_mem[pos] = '0;
                pos = pos + 6'd1;
                out_fifo.push_back(r);
            end
        endcase
    endtask

    // Drive one word, honoring the burst/gap pattern of the sender.
    int burst_left = 0;
    task automatic send_word(input conv_word_t w);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {3'd0, w};
        do @(posedge aclk); while (!s_tready);
        predict_conv(w);
    endtask

    // Drop valid after the last word of a stretch.
    task automatic idle_sender();
        s_tvalid <= 1'b0;
        burst_left = 0;
    endtask

    // Write a register over APB: setup then access.
    task automatic apb_write(input logic [1:0] addr, input logic [31:0] data);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= addr; pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr == 2'd0) taps_reg = data[4:0];
    endtask

    // Let the block drain: all results seen, then room for a long end load.
    task automatic drain_idle();
        idle_sender();
        while (out_fifo.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    function automatic conv_word_t mk(input logic [1:0] op, input logic [3:0] tap,
                                      input logic [5:0] lag, input logic [31:0] coef,
                                      input logic [15:0] blen, input logic [31:0] smp,
                                      input logic [31:0] pri, input logic act);
        conv_word_t w;
        w = '{act, pri, smp, blen, coef, lag, tap, op};
        return w;
    endfunction

    function automatic dir_row_t mk_row(input conv_word_t w, input logic has_exp,
                                        input logic sat, input logic [31:0] val);
        dir_row_t r;
        r.w = w;
        r.has_exp = has_exp;
        r.exp.saturated = sat;
        r.exp.out_value = val;
        return r;
    endfunction

    function automatic logic [31:0] rnd32();
        case ($urandom_range(0, 5))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< $urandom_range(0, 24);
            default: return $urandom;
        endcase
    endfunction

    // Receiver: stall on its own pattern, check each word against the oldest entry.
    initial begin : receiver
        conv_out_t got, want;
        int phase;
        phase = 0;
        @(posedge aresetn);
        forever begin
            phase++;
            m_tready <= ((phase / 40) % 3 == 0) ? 1'b1 : ($urandom_range(0, 3) != 0);
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                got = m_tdata[32:0];
                if (out_fifo.size() == 0) begin
                    report_mismatch("unexpected word", m_tdata, 0);
                end else begin
                    want = out_fifo.pop_front();
                    if (got.out_value !== want.out_value)
                        report_mismatch("out_value", got.out_value, want.out_value);
                    if (got.saturated !== want.saturated)
                        report_mismatch("saturated", got.saturated, want.saturated);
                end
            end
        end
    end

    // Directed table; typed expectations where obvious, the predictor elsewhere.
    dir_row_t dir_tbl[$];

    initial begin : stimulus
        conv_word_t w;
        int n_res;
        taps_reg = 5'd1;
        pos = '0;
        for (int i = 0; i < NTAPS; i++) begin
            lag_mem[i] = '0; coef_cur[i] = '0; coef_inc[i] = '0;
        end
        for (int i = 0; i < WIN; i++) acc_mem[i] = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // After reset: zero coefficients, prior passes through; extremes of prior.
        dir_tbl.push_back(mk_row(mk(OP_SAMP, 0, 0, 0, 0, 32'h7fff_ffff, 32'h7fff_ffff, 1),
                                 1'b1, 1'b0, 32'h7fff_ffff));
        dir_tbl.push_back(mk_row(mk(OP_SAMP, 0, 0, 0, 0, 32'h8000_0000, 32'h8000_0000, 0),
                                 1'b1, 1'b0, 32'h8000_0000));
        dir_tbl.push_back(mk_row(mk(OP_LAG, 0, 6'd63, 0, 0, 0, 0, 0), 1'b0, 1'b0, 0));
        dir_tbl.push_back(mk_row(mk(OP_LAG, 4'd15, 6'd1, 0, 0, 0, 0, 0), 1'b0, 1'b0, 0));
        dir_tbl.push_back(mk_row(mk(OP_BEGIN, 0, 0, 32'h7fff_ffff, 0, 0, 0, 0), 1'b0, 1'b0, 0));
        dir_tbl.push_back(mk_row(mk(OP_END, 0, 0, 32'h8000_0000, 16'd0, 0, 0, 0),
                                 1'b0, 1'b0, 0)); // zero length
        dir_tbl.push_back(mk_row(mk(OP_SAMP, 0, 0, 0, 0, 32'h7fff_ffff, 32'h7fff_ffff, 1),
                                 1'b0, 1'b0, 0));
        dir_tbl.push_back(mk_row(mk(OP_SAMP, 0, 0, 0, 0, 32'h8000_0000, 32'h8000_0000, 1),
                                 1'b0, 1'b0, 0));
        dir_tbl.push_back(mk_row(mk(OP_END, 4'd15, 0, 32'h7fff_ffff, 16'hffff, 0, 0, 0),
                                 1'b0, 1'b0, 0)); // end first
        dir_tbl.push_back(mk_row(mk(OP_BEGIN, 4'd15, 0, 32'h8000_0000, 0, 0, 0, 0),
                                 1'b0, 1'b0, 0));
        dir_tbl.push_back(mk_row(mk(OP_END, 4'd1, 0, 32'h1000_0000, 16'd4, 0, 0, 0),
                                 1'b0, 1'b0, 0));
        for (int i = 0; i < 6; i++)
            dir_tbl.push_back(mk_row(mk(OP_SAMP, 0, 0, 0, 0, 32'h0100_0000, 32'h0, 1'(i % 2)),
                                     1'b0, 1'b0, 0));
        foreach (dir_tbl[i]) begin
            send_word(dir_tbl[i].w);
            if (dir_tbl[i].has_exp) out_fifo[out_fifo.size() - 1] = dir_tbl[i].exp;
        end
        drain_idle();

        // Random phases over several tap counts, the extremes included.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: apb_write(2'd0, 32'd16);
                1: apb_write(2'd0, 32'd0);
                2: apb_write(2'd0, 32'd31);
                3: apb_write(2'd1, 32'd3);     // not a register: ignored
                4: apb_write(2'd0, 32'($urandom_range(1, 15)));
                default: apb_write(2'd0, 32'd1);
            endcase
            n_res = 0;
            while (n_res < N_RAND / 6) begin
                w = '0;
                w.op = ($urandom_range(0, 9) < 6) ? OP_SAMP : 2'($urandom_range(0, 2));
                w.tap = 4'($urandom);
                w.lag_value = 6'($urandom);
                w.coef = rnd32();
                w.block_len = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 1))
                                                          : 16'($urandom);
                w.sample = rnd32();
                w.prior = rnd32();
                w.active = ($urandom_range(0, 4) != 0);
                send_word(w);
                n_res++;
                // Hold off once until every result is back.
                if (ph == 2 && n_res == 50) begin
                    idle_sender();
                    while (out_fifo.size() != 0) @(posedge aclk);
                end
            end
            drain_idle();
        end
        sender_done = 1'b1;
    end

    initial begin : finisher
        wait (sender_done);
        if (err_cnt == 0 && out_fifo.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Slow correct run: ~900 words plus stalls and gaps.
    initial begin : watchdog
        #(10 * 600000);
        $display("Regression FAIL");
        $finish;
    end
endmodule
`default_nettype wire
